// ----- rtl/touch_sample_gesture_classifier_defines.svh -----
// Assertion macros for the touch sample gesture classifier.
`ifndef TOUCH_SAMPLE_GESTURE_CLASSIFIER_DEFINES_SVH
`define TOUCH_SAMPLE_GESTURE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTH
// Checked on clk while the block is out of reset.
`define TSGC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("tsgc assertion failed");
// Checked on clk at every edge, reset included.
`define TSGC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("tsgc assertion failed");
`else
`define TSGC_ASSERT(lbl, prop)
`define TSGC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/tsgc_pkg.sv -----
// Types and constants shared by the touch sample gesture classifier files.
package tsgc_pkg;

	// Field widths
	localparam int RAW_W      = 12;
	localparam int TIME_W     = 32;
	localparam int SX_W       = 9;
	localparam int SY_W       = 8;
	localparam int ACT_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Screen geometry; SIZE_W holds the larger screen dimension
	localparam int SIZE_W = 9;
	localparam logic [SIZE_W-1:0] SCREEN_WIDTH  = 9'd320;
	localparam logic [SIZE_W-1:0] SCREEN_HEIGHT = 9'd240;
	localparam logic [SX_W-1:0]   HALF_X        = SX_W'(SCREEN_WIDTH >> 1);

	// Magnitude of (raw - cal) * size, and divider step count width
	localparam int MAG_W = RAW_W + SIZE_W;
	localparam int CNT_W = $clog2(MAG_W + 1);

	// Gesture and filter constants
	localparam logic [SX_W:0]       SWIPE_PIXELS  = 10'd40;
	localparam logic [SX_W:0]       SWIPE_HALF    = SWIPE_PIXELS >> 1;
	localparam logic [TIME_W-1:0]   DEBOUNCE_MS   = 32'd120;
	localparam logic [RAW_W-1:0]    PRESSURE_LOW  = 12'd180;
	localparam logic [RAW_W-1:0]    PRESSURE_HIGH = 12'd4000;

	// Settings screen layout
	localparam int NUM_ROWS = 3;
	localparam logic [SY_W-1:0] ROW_SPAN  = 8'd52;
	localparam logic [SY_W-1:0] EXIT_BAND = 8'd28;
	localparam logic [SY_W-1:0] EXIT_Y    = SY_W'(SCREEN_HEIGHT) - EXIT_BAND;
	localparam logic [SY_W-1:0] ROW_TOPS [NUM_ROWS] = '{8'd36, 8'd96, 8'd156};

	// Action codes
	localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ENTER  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_EXIT   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RESCAN = 3'd3;
	localparam logic [ACT_W-1:0] ACT_BRIGHT = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DICT   = 3'd5;
	localparam logic [ACT_W-1:0] ACT_VAR    = 3'd6;
	localparam logic [ACT_W-1:0] ACT_REDRAW = 3'd7;

	localparam logic [ACT_W-1:0] ROW_ACTS [NUM_ROWS] = '{ACT_BRIGHT, ACT_DICT, ACT_VAR};

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIN_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_MAX_X  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIN_Y  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_MAX_Y  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RADAR_L    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RADAR_T    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RADAR_W    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RADAR_H    = 3'd7;

endpackage

// ----- rtl/tsgc_sample_if.sv -----
// Touch sample input channel.
interface tsgc_sample_if import tsgc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              touched;
	logic [RAW_W-1:0]  raw_x;
	logic [RAW_W-1:0]  raw_y;
	logic [RAW_W-1:0]  pressure;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, touched, raw_x, raw_y, pressure, now_ms, input ready);
	modport sink   (input valid, touched, raw_x, raw_y, pressure, now_ms, output ready);
endinterface

// ----- rtl/tsgc_result_if.sv -----
// Classified result output channel.
interface tsgc_result_if import tsgc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic             increase;
	logic [SX_W-1:0]  screen_x;
	logic [SY_W-1:0]  screen_y;
	logic             settings_mode;
	logic             accepted;

	modport source (output valid, action, increase, screen_x, screen_y, settings_mode,
		accepted, input ready);
	modport sink   (input valid, action, increase, screen_x, screen_y, settings_mode,
		accepted, output ready);
endinterface

// ----- rtl/tsgc_cfg_if.sv -----
// Configuration register write channel.
interface tsgc_cfg_if import tsgc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/touch_sample_gesture_classifier.sv -----
// A lifted or out-of-window sample skips the divider: ST_IDLE goes straight to ST_OUT.
// An accepted sample maps X then Y through one shared restoring divider (MAG_W = 21 steps
// each, plus a multiply and a clamp state per axis), then passes ST_CLASS and ST_OUT.
// A new sample is taken only in ST_IDLE, once the last result is in the output register.
// Reset (arst_n low, asynchronous): calibration and radar registers to defaults,
// swipe tracking, debounce time and mode cleared, output channel empty.
module touch_sample_gesture_classifier import tsgc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	tsgc_sample_if.sink     sample,
	tsgc_result_if.source   result,
	tsgc_cfg_if.sink        cfg
);

	`include "touch_sample_gesture_classifier_defines.svh"

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_FIX   = 3'd3;
	localparam logic [2:0] ST_CLASS = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q;
	logic       axis_q;

	// Configuration
	logic [RAW_W-1:0] cal_min_x_q, cal_max_x_q, cal_min_y_q, cal_max_y_q;
	logic [SX_W-1:0]  radar_left_q, radar_width_q;
	logic [SY_W-1:0]  radar_top_q, radar_height_q;

	// Sample latch
	logic [RAW_W-1:0]  rx_q, ry_q;
	logic [TIME_W-1:0] now_q;

	// Divider
	logic [RAW_W-1:0] rem_q;
	logic [RAW_W-1:0] dvs_q;
	logic [MAG_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             zero_q;

	// Results and tracking state
	logic [SX_W-1:0]   sx_q, start_x_q;
	logic [SY_W-1:0]   sy_q, start_y_q;
	logic [ACT_W-1:0]  act_q;
	logic              inc_q, acc_q;
	logic              active_q, fired_q, mode_q;
	logic [TIME_W-1:0] last_q;

	// Output register
	logic              out_valid_q;
	logic [ACT_W-1:0]  out_action_q;
	logic              out_inc_q, out_mode_q, out_acc_q;
	logic [SX_W-1:0]   out_sx_q;
	logic [SY_W-1:0]   out_sy_q;

	logic sample_fire, out_load, in_window;

	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign sample_fire  = sample.valid && sample.ready;
	assign out_load     = (state_q == ST_OUT) && (!out_valid_q || result.ready);
	assign in_window    = (sample.pressure >= PRESSURE_LOW) && (sample.pressure <= PRESSURE_HIGH);

	assign result.valid         = out_valid_q;
	assign result.action        = out_action_q;
	assign result.increase      = out_inc_q;
	assign result.screen_x      = out_sx_q;
	assign result.screen_y      = out_sy_q;
	assign result.settings_mode = out_mode_q;
	assign result.accepted      = out_acc_q;

	// Axis operand select and product magnitude
	logic [RAW_W-1:0]  raw_sel, from_sel, to_sel;
	logic [SIZE_W-1:0] size_sel, size_m1;
	logic [RAW_W:0]    diff, span, diff_neg, span_neg;
	logic [RAW_W-1:0]  diff_mag, span_mag;
	logic [MAG_W-1:0]  prod;

	always_comb begin
		raw_sel  = axis_q ? ry_q : rx_q;
		from_sel = axis_q ? cal_max_y_q : cal_min_x_q;
		to_sel   = axis_q ? cal_min_y_q : cal_max_x_q;
		size_sel = axis_q ? SCREEN_HEIGHT : SCREEN_WIDTH;
		size_m1  = size_sel - 1'b1;
		diff     = {1'b0, raw_sel} - {1'b0, from_sel};
		span     = {1'b0, to_sel} - {1'b0, from_sel};
		diff_neg = (RAW_W+1)'(0) - diff;
		span_neg = (RAW_W+1)'(0) - span;
		diff_mag = diff[RAW_W] ? diff_neg[RAW_W-1:0] : diff[RAW_W-1:0];
		span_mag = span[RAW_W] ? span_neg[RAW_W-1:0] : span[RAW_W-1:0];
		prod     = {{SIZE_W{1'b0}}, diff_mag} * {{RAW_W{1'b0}}, size_sel};
	end

	// One restoring divide step
	logic [RAW_W:0]   rem_sh, rem_sub;
	logic             step_ge;

	always_comb begin
		rem_sh  = {rem_q, quo_q[MAG_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		step_ge = rem_sh >= {1'b0, dvs_q};
	end

	// Clamp of the quotient to the screen
	logic [SIZE_W-1:0] clamped;

	always_comb begin
		if (zero_q)
			clamped = '0;
		else if (quo_q > {{(MAG_W-SIZE_W){1'b0}}, size_m1})
			clamped = size_m1;
		else
			clamped = quo_q[SIZE_W-1:0];
	end

	// Swipe, debounce and region classification
	logic              swipe, deb_ok, row_hit, in_radar, right;
	logic [SY_W-1:0]   dy_abs;
	logic [SX_W:0]     dx_back, r_edge;
	logic [SY_W:0]     b_edge;
	logic [TIME_W-1:0] elapsed;
	logic [ACT_W-1:0]  row_act, act_n;
	logic              inc_n, mode_n, time_upd;

	always_comb begin
		dx_back  = {1'b0, start_x_q} - {1'b0, sx_q};
		dy_abs   = (sy_q >= start_y_q) ? (sy_q - start_y_q) : (start_y_q - sy_q);
		swipe    = active_q && !fired_q && (start_x_q >= sx_q) && (dx_back >= SWIPE_PIXELS)
			&& ({2'b00, dy_abs} < SWIPE_HALF);
		elapsed  = now_q - last_q;
		deb_ok   = elapsed >= DEBOUNCE_MS;
		right    = sx_q >= HALF_X;
		r_edge   = {1'b0, radar_left_q} + {1'b0, radar_width_q};
		b_edge   = {1'b0, radar_top_q} + {1'b0, radar_height_q};
		in_radar = (sx_q >= radar_left_q) && ({1'b0, sx_q} <= r_edge)
			&& (sy_q >= radar_top_q) && ({1'b0, sy_q} <= b_edge);
		row_hit  = 1'b0;
		row_act  = ACT_REDRAW;
		for (int k = NUM_ROWS - 1; k >= 0; k--) begin
			if (sy_q >= ROW_TOPS[k] && {1'b0, sy_q} <= {1'b0, ROW_TOPS[k]} + {1'b0, ROW_SPAN}) begin
				row_hit = 1'b1;
				row_act = ROW_ACTS[k];
			end
		end

		act_n    = ACT_NONE;
		inc_n    = 1'b0;
		mode_n   = mode_q;
		time_upd = 1'b0;
		if (swipe) begin
			mode_n   = !mode_q;
			act_n    = mode_q ? ACT_EXIT : ACT_ENTER;
			time_upd = 1'b1;
		end else if (deb_ok) begin
			time_upd = 1'b1;
			if (mode_q) begin
				act_n = ACT_REDRAW;
				if (row_hit) begin
					act_n = row_act;
					inc_n = right;
				end else if (sy_q >= EXIT_Y) begin
					mode_n = 1'b0;
					act_n  = ACT_EXIT;
				end
			end else if (in_radar) begin
				act_n = ACT_RESCAN;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_x_q    <= '0;
			cal_max_x_q    <= '1;
			cal_min_y_q    <= '0;
			cal_max_y_q    <= '1;
			radar_left_q   <= '0;
			radar_top_q    <= '0;
			radar_width_q  <= '0;
			radar_height_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_CAL_MIN_X: cal_min_x_q    <= cfg.data;
				CFG_CAL_MAX_X: cal_max_x_q    <= cfg.data;
				CFG_CAL_MIN_Y: cal_min_y_q    <= cfg.data;
				CFG_CAL_MAX_Y: cal_max_y_q    <= cfg.data;
				CFG_RADAR_L:   radar_left_q   <= cfg.data[SX_W-1:0];
				CFG_RADAR_T:   radar_top_q    <= cfg.data[SY_W-1:0];
				CFG_RADAR_W:   radar_width_q  <= cfg.data[SX_W-1:0];
				CFG_RADAR_H:   radar_height_q <= cfg.data[SY_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			active_q    <= 1'b0;
			fired_q     <= 1'b0;
			start_x_q   <= '0;
			start_y_q   <= '0;
			last_q      <= '0;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			// output register fills on a load, empties when taken
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (sample_fire) begin
						axis_q <= 1'b0;
						if (!sample.touched) begin
							active_q <= 1'b0;
							fired_q  <= 1'b0;
							state_q  <= ST_OUT;
						end else if (!in_window) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					cnt_q   <= CNT_W'(MAG_W);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1))
						state_q <= ST_FIX;
				end
				ST_FIX: begin
					axis_q  <= 1'b1;
					state_q <= axis_q ? ST_CLASS : ST_MUL;
				end
				ST_CLASS: begin
					if (!active_q) begin
						active_q  <= 1'b1;
						fired_q   <= 1'b0;
						start_x_q <= sx_q;
						start_y_q <= sy_q;
					end else if (swipe) begin
						fired_q <= 1'b1;
					end
					mode_q <= mode_n;
					if (time_upd)
						last_q <= now_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: sample latch, divider, per-item results, output payload
	always_ff @(posedge clk) begin
		if (sample_fire) begin
			rx_q  <= sample.raw_x;
			ry_q  <= sample.raw_y;
			now_q <= sample.now_ms;
			sx_q  <= '0;
			sy_q  <= '0;
			act_q <= ACT_NONE;
			inc_q <= 1'b0;
			acc_q <= sample.touched && in_window;
		end
		if (state_q == ST_MUL) begin
			quo_q  <= prod;
			rem_q  <= '0;
			dvs_q  <= span_mag;
			zero_q <= (span_mag == '0) || (diff[RAW_W] != span[RAW_W]);
		end
		if (state_q == ST_DIV) begin
			rem_q <= step_ge ? rem_sub[RAW_W-1:0] : rem_sh[RAW_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], step_ge};
		end
		if (state_q == ST_FIX) begin
			if (axis_q)
				sy_q <= clamped[SY_W-1:0];
			else
				sx_q <= clamped[SX_W-1:0];
		end
		if (state_q == ST_CLASS) begin
			act_q <= act_n;
			inc_q <= inc_n;
		end
		if (out_load) begin
			out_action_q <= act_q;
			out_inc_q    <= inc_q;
			out_sx_q     <= sx_q;
			out_sy_q     <= sy_q;
			out_mode_q   <= mode_q;
			out_acc_q    <= acc_q;
		end
	end

	// Checks
	`TSGC_ASSERT(a_busy_after_take, sample_fire |=> state_q != ST_IDLE)
	`TSGC_ASSERT(a_div_count_live, state_q == ST_DIV |-> cnt_q != '0)
	`TSGC_ASSERT(a_mode_from_class, mode_q != $past(mode_q) |-> $past(state_q) == ST_CLASS)
	`TSGC_ASSERT(a_reject_is_blank, result.valid && !result.accepted |->
		result.action == ACT_NONE && result.screen_x == '0 && result.screen_y == '0)
	`TSGC_ASSERT(a_inc_only_adjust, result.valid && result.increase |->
		result.action == ACT_BRIGHT || result.action == ACT_DICT || result.action == ACT_VAR)
	`TSGC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !result.valid && sample.ready)

endmodule
